@@ hw/rtl/dq_pkg.sv @@
`timescale 1ns / 1ps
// dq_pkg: shared constants, codes and types for the double-ended queue.
// No dependencies; imported by every module of the block.
package dq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [2:0] {
		MD_PUSH_FRONT = 3'd0,
		MD_PUSH_REAR  = 3'd1,
		MD_POP_FRONT  = 3'd2,
		MD_POP_REAR   = 3'd3,
		MD_PEEK_FRONT = 3'd4,
		MD_PEEK_REAR  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	// one-hot per cycle: at most one of these is set
	typedef struct packed {
		logic shift_r;
		logic shift_l;
		logic put_rear;
		logic drop_rear;
	} dq_op_t;

endpackage

@@ hw/rtl/dq_cell.sv @@
`timescale 1ns / 1ps
// dq_cell: one storage position of the queue chain, word plus occupied flag.
// Depends on dq_pkg.
module dq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  dq_pkg::dq_op_t  op,
	input  dq_pkg::word_t   push_value,
	input  dq_pkg::word_t   prev_data,
	input  logic            prev_occ,
	input  dq_pkg::word_t   next_data,
	input  logic            next_occ,
	output dq_pkg::word_t   data,
	output logic            occ
);
	import dq_pkg::*;

	word_t data_q;
	logic  occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			priority if (op.shift_r) begin
				occ_q <= prev_occ;
			end else if (op.shift_l) begin
				occ_q <= next_occ;
			end else if (op.put_rear && !occ_q && prev_occ) begin
				occ_q <= 1'b1;
			end else if (op.drop_rear && occ_q && !next_occ) begin
				occ_q <= 1'b0;
			end else begin
				occ_q <= occ_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (op.shift_r) begin
			data_q <= prev_data;
		end else if (op.shift_l) begin
			data_q <= next_data;
		end else if (op.put_rear && !occ_q && prev_occ) begin
			data_q <= push_value;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;
	assign occ  = occ_q;

endmodule

@@ hw/rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// double_ended_queue: top level, a chain of dq_cell positions with the front
// held in cell 0, operation decode and a registered response. Depends on dq_pkg.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  mode, push_value
//  rsp      out        rsp_valid/rsp_ready  read_value, status, occupancy
//
// One request per cycle; its response appears in the response register on
// the next cycle. A push at the front shifts the whole chain by one cell in
// the same cycle. Requests are taken while the response register is empty or
// being drained, so a stalled response stalls requests after one. Reset
// empties the queue at once; word contents are left as they are.
module double_ended_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [2:0]                  mode,
	input  dq_pkg::word_t               push_value,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output dq_pkg::word_t               read_value,
	output logic [1:0]                  status,
	output logic [dq_pkg::CNT_W-1:0]    occupancy
);
	import dq_pkg::*;

	word_t   cell_data [DEPTH];
	logic    [DEPTH-1:0] cell_occ;
	logic    [DEPTH-1:0] occ_after;
	dq_op_t  op;
	count_t  count_q;
	count_t  count_d;
	status_t st;
	word_t   rd;
	word_t   rear_data;
	logic    accept;
	logic    full;
	logic    empty;

	logic    rsp_valid_q;
	word_t   read_value_q;
	status_t status_q;
	count_t  occupancy_q;

	assign accept    = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign full      = (count_q == count_t'(DEPTH));
	assign empty     = (count_q == '0);
	assign occ_after = {1'b0, cell_occ[DEPTH-1:1]};

	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_occ[i] && !occ_after[i])
				rear_data = rear_data | cell_data[i];
		end
	end

	always_comb begin
		op      = '0;
		st      = ST_OK;
		rd      = '0;
		count_d = count_q;
		unique case (mode)
			MD_PUSH_FRONT, MD_PUSH_REAR: begin
				if (full) begin
					st = ST_OVER;
				end else begin
					op.shift_r  = (mode == MD_PUSH_FRONT);
					op.put_rear = (mode == MD_PUSH_REAR);
					count_d     = count_q + count_t'(1);
				end
			end
			MD_POP_FRONT, MD_PEEK_FRONT: begin
				if (empty) begin
					st = ST_UNDER;
				end else begin
					rd = cell_data[0];
					if (mode == MD_POP_FRONT) begin
						op.shift_l = 1'b1;
						count_d    = count_q - count_t'(1);
					end
				end
			end
			MD_POP_REAR, MD_PEEK_REAR: begin
				if (empty) begin
					st = ST_UNDER;
				end else begin
					rd = rear_data;
					if (mode == MD_POP_REAR) begin
						op.drop_rear = 1'b1;
						count_d      = count_q - count_t'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (!accept)
			op = '0;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t pd;
		word_t nd;
		logic  po;
		logic  no;
		if (i == 0) begin : g_first
			assign pd = push_value;
			assign po = 1'b1;
		end else begin : g_mid
			assign pd = cell_data[i-1];
			assign po = cell_occ[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign nd = '0;
			assign no = 1'b0;
		end else begin : g_inner
			assign nd = cell_data[i+1];
			assign no = cell_occ[i+1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.push_value (push_value),
			.prev_data  (pd),
			.prev_occ   (po),
			.next_data  (nd),
			.next_occ   (no),
			.data       (cell_data[i]),
			.occ        (cell_occ[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd;
			status_q     <= st;
			occupancy_q  <= count_d;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign occupancy  = occupancy_q;

endmodule

@@ hw/rtl/dq_checker.sv @@
`timescale 1ns / 1ps
// dq_checker: port-level assertions for double_ended_queue, bound to the top.
// Depends on dq_pkg and double_ended_queue.
module dq_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input dq_pkg::word_t            read_value,
	input logic [1:0]               status,
	input logic [dq_pkg::CNT_W-1:0] occupancy
);
	import dq_pkg::*;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupancy <= count_t'(DEPTH))
		else $error("occupancy above depth");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OVER |-> occupancy == count_t'(DEPTH) && read_value == '0)
		else $error("overflow without full queue");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_UNDER |-> occupancy == '0 && read_value == '0)
		else $error("underflow without empty queue");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(status))
		else $error("response changed while stalled");

	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request without response");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.read_value (read_value),
	.status     (status),
	.occupancy  (occupancy)
);
